### rtl/cdd_pkg.sv
// shared types, constants and the month table for the calendar date to day number block
// no dependencies; used by every module under rtl
package cdd_pkg;

  // calendar mode codes (value 3 acts as automatic)
  localparam logic [1:0] MODE_AUTO      = 2'd0;
  localparam logic [1:0] MODE_JULIAN    = 2'd1;
  localparam logic [1:0] MODE_GREGORIAN = 2'd2;

  // day origin codes (value 3 acts as plain day number)
  localparam logic [1:0] ORIGIN_JDN = 2'd0;
  localparam logic [1:0] ORIGIN_MJD = 2'd1;
  localparam logic [1:0] ORIGIN_TJD = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_CALENDAR_MODE = 1'b0;
  localparam logic REG_DAY_ORIGIN    = 1'b1;

  localparam int AddrWidth = 3;
  localparam int DataWidth = 32;

  // reform date
  localparam logic signed [15:0] REFORM_YEAR    = 16'sd1582;
  localparam logic        [3:0]  REFORM_MONTH   = 4'd10;
  localparam logic        [4:0]  LAST_JULIAN_DAY = 5'd5;
  localparam logic        [4:0]  FIRST_GREG_DAY  = 5'd15;

  // year bias keeps the divide-by-100 operand non-negative (82 * 400)
  localparam logic signed [17:0] YEAR_BIAS = 18'sd32800;
  // reciprocal of 100, exact for operands below 91199 (biased years stay under 65568)
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int          RecipShift  = 23;
  localparam logic [16:0] HUNDRED     = 17'd100;

  // year-zero day numbers; gregorian one folds in the bias of both century terms
  localparam logic signed [24:0] JULIAN_BASE    = 25'sd1721058;
  localparam logic signed [24:0] GREGORIAN_BASE = 25'sd1721306;
  localparam logic signed [24:0] DAYS_PER_YEAR  = 25'sd365;
  localparam logic signed [24:0] MJD_OFFSET     = 25'sd2400001;
  localparam logic signed [24:0] TJD_OFFSET     = 25'sd2440001;

  // front stage payload
  typedef struct packed {
    logic signed [15:0] y;        // astronomical year
    logic        [16:0] u;        // biased year
    logic signed [9:0]  doy;      // day of year without leap day
    logic               march_on; // month past february
    logic               use_greg;
    logic               gap;
  } cdd_front_t;

  // divide stage payload
  typedef struct packed {
    logic signed [24:0] y365;
    logic signed [14:0] y4;       // floor((y + 3) / 4)
    logic        [1:0]  y_low;
    logic        [9:0]  q;        // biased year / 100
    logic        [6:0]  r;        // biased year % 100
    logic signed [9:0]  doy;
    logic               march_on;
    logic               use_greg;
    logic               gap;
  } cdd_recip_t;

  // days before the first of each month, zero for codes outside 1..12
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/calendar_date_to_day_number.sv
// top level of the calendar date to day number converter
// depends on cdd_pkg, cdd_front, cdd_recip and cdd_total
//
// Converts one calendar date per clock into an integer day count while
// the output is not stalled. A date enters on in_valid/in_ready and its
// result leaves on out_valid/out_ready; the five register stages (decode,
// multiply, divide by 100, sum, origin offset) each hold one date, so a
// new date is taken every cycle and a stalled output only holds full stages.
// Years are historical (negative is BC, year zero acts as 1 BC). Register 0
// (byte address 0) picks the calendar: 0 automatic switch at the 1582
// reform, 1 proleptic Julian, 2 proleptic Gregorian, 3 same as automatic.
// Register 1 (byte address 4) picks the origin: 0 Julian day number, 1 MJD,
// 2 TJD, 3 same as 0. In automatic mode, 6 to 14 Oct 1582 set gap_error and
// give day_value 0. The user must write the registers over the APB port only
// while no date is in flight; the block does not enforce this.
module calendar_date_to_day_number (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdd_pkg::AddrWidth-1:0] paddr,
  input  logic [cdd_pkg::DataWidth-1:0] pwdata,
  output logic [cdd_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  // date request
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            year,
  input  logic        [3:0]             month,
  input  logic        [4:0]             day_of_month,
  // day number result
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [24:0]            day_value,
  output logic                          gap_error
);
  import cdd_pkg::*;

  logic [1:0] calendar_mode;
  logic [1:0] day_origin;
  logic       cfg_write;

  cdd_front_t front_data;
  logic       front_valid;
  logic       front_ready;
  cdd_recip_t recip_data;
  logic       recip_valid;
  logic       recip_ready;

  // no wait states on the register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // register file: index comes from address bit 2
  always_ff @(posedge clk) begin
    if (rst) begin
      calendar_mode <= MODE_AUTO;
      day_origin    <= ORIGIN_JDN;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_CALENDAR_MODE: calendar_mode <= pwdata[1:0];
        REG_DAY_ORIGIN:    day_origin    <= pwdata[1:0];
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (paddr[2])
      REG_CALENDAR_MODE: prdata = {{(DataWidth-2){1'b0}}, calendar_mode};
      REG_DAY_ORIGIN:    prdata = {{(DataWidth-2){1'b0}}, day_origin};
    endcase
  end

  // stage 1: astronomical year, day of year, calendar choice and gap check
  cdd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .year          (year),
    .month         (month),
    .day_of_month  (day_of_month),
    .calendar_mode (calendar_mode),
    .out_valid     (front_valid),
    .out_ready     (front_ready),
    .out_data      (front_data)
  );

  // stages 2 and 3: year products and century split
  cdd_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (recip_valid),
    .out_ready (recip_ready),
    .out_data  (recip_data)
  );

  // stages 4 and 5: day number, origin offset, output register
  cdd_total u_total (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (recip_valid),
    .in_ready   (recip_ready),
    .in_data    (recip_data),
    .day_origin (day_origin),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .day_value  (day_value),
    .gap_error  (gap_error)
  );

endmodule

### rtl/cdd_front.sv
// first pipeline stage: astronomical year, day of year, calendar choice
// depends on cdd_pkg
module cdd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  year,
  input  logic        [3:0]   month,
  input  logic        [4:0]   day_of_month,
  input  logic        [1:0]   calendar_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output cdd_pkg::cdd_front_t out_data
);
  import cdd_pkg::*;

  cdd_front_t data_next;
  logic       early;
  logic       late;
  logic signed [15:0] y_astro;
  logic signed [17:0] u_wide;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    y_astro = year + {15'd0, year[15]};
    u_wide  = 18'(y_astro) + YEAR_BIAS;
    early = (year < REFORM_YEAR)
         || (year == REFORM_YEAR && month < REFORM_MONTH)
         || (year == REFORM_YEAR && month == REFORM_MONTH && day_of_month <= LAST_JULIAN_DAY);
    late  = (year > REFORM_YEAR)
         || (year == REFORM_YEAR && month > REFORM_MONTH)
         || (year == REFORM_YEAR && month == REFORM_MONTH && day_of_month >= FIRST_GREG_DAY);

    data_next.y        = y_astro;
    data_next.u        = u_wide[16:0];
    data_next.doy      = $signed({5'd0, day_of_month}) + $signed({1'b0, days_before(month)})
                       - 10'sd1;
    data_next.march_on = (month >= 4'd3) && (month <= 4'd12);
    unique case (calendar_mode)
      MODE_JULIAN: begin
        data_next.use_greg = 1'b0;
        data_next.gap      = 1'b0;
      end
      MODE_GREGORIAN: begin
        data_next.use_greg = 1'b1;
        data_next.gap      = 1'b0;
      end
      default: begin
        data_next.use_greg = !early;
        data_next.gap      = !early && !late;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/cdd_recip.sv
// second and third pipeline stages: year times 365, quarter years,
// and biased year split by 100 through a reciprocal multiply
// depends on cdd_pkg
module cdd_recip (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdd_pkg::cdd_front_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cdd_pkg::cdd_recip_t out_data
);
  import cdd_pkg::*;

  typedef struct packed {
    logic [33:0]        prod;
    logic [16:0]        u;
    logic signed [24:0] y365;
    logic signed [14:0] y4;
    logic [1:0]         y_low;
    logic signed [9:0]  doy;
    logic               march_on;
    logic               use_greg;
    logic               gap;
  } mul_stage_t;

  mul_stage_t mul_q;
  mul_stage_t mul_next;
  logic       mul_valid;
  logic       mul_ready;
  cdd_recip_t data_next;
  logic signed [16:0] y_plus3;
  logic [9:0]  quot;
  logic [16:0] rem_wide;

  assign mul_ready = !out_valid || out_ready;
  assign in_ready  = !mul_valid || mul_ready;

  always_comb begin
    y_plus3 = 17'(in_data.y) + 17'sd3;
    mul_next.prod     = {17'd0, in_data.u} * {17'd0, RECIP_100};
    mul_next.u        = in_data.u;
    mul_next.y365     = 25'(in_data.y) * DAYS_PER_YEAR;
    mul_next.y4       = 15'(y_plus3 >>> 2);
    mul_next.y_low    = in_data.y[1:0];
    mul_next.doy      = in_data.doy;
    mul_next.march_on = in_data.march_on;
    mul_next.use_greg = in_data.use_greg;
    mul_next.gap      = in_data.gap;
  end

  always_comb begin
    quot     = mul_q.prod[RecipShift +: 10];
    rem_wide = mul_q.u - {7'd0, quot} * HUNDRED;
    data_next.y365     = mul_q.y365;
    data_next.y4       = mul_q.y4;
    data_next.y_low    = mul_q.y_low;
    data_next.q        = quot;
    data_next.r        = rem_wide[6:0];
    data_next.doy      = mul_q.doy;
    data_next.march_on = mul_q.march_on;
    data_next.use_greg = mul_q.use_greg;
    data_next.gap      = mul_q.gap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mul_valid <= in_valid;
      end
      if (mul_ready) begin
        out_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul_q <= mul_next;
    end
    if (mul_ready && mul_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/cdd_total.sv
// fourth and fifth pipeline stages: leap day, day number sum, origin offset
// depends on cdd_pkg
module cdd_total (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdd_pkg::cdd_recip_t in_data,
  input  logic [1:0]          day_origin,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [24:0]  day_value,
  output logic                gap_error
);
  import cdd_pkg::*;

  logic               sum_valid;
  logic               sum_ready;
  logic signed [24:0] jdn;
  logic               jdn_gap;
  logic signed [24:0] jdn_next;
  logic signed [24:0] value_next;
  logic signed [24:0] offset;
  logic signed [11:0] corr;
  logic               leap;
  logic               rem_zero;
  logic               cent_zero;
  logic signed [9:0]  doy_full;

  assign sum_ready = !out_valid || out_ready;
  assign in_ready  = !sum_valid || sum_ready;

  always_comb begin
    rem_zero  = (in_data.r == 7'd0);
    cent_zero = (in_data.q[1:0] == 2'd0);
    // century years not divisible by 400 drop the leap day under gregorian rules
    leap = (in_data.y_low == 2'd0) && !(in_data.use_greg && rem_zero && !cent_zero);
    doy_full = in_data.doy + {9'd0, leap && in_data.march_on};
    // -floor((y+99)/100) + floor((y+399)/400), biases folded into the base
    corr = $signed({4'd0, in_data.q[9:2]}) - $signed({2'd0, in_data.q})
         - $signed({11'd0, !rem_zero}) + $signed({11'd0, !(rem_zero && cent_zero)});
    jdn_next = in_data.y365 + 25'(in_data.y4) + 25'(doy_full)
             + (in_data.use_greg ? (GREGORIAN_BASE + 25'(corr)) : JULIAN_BASE);
  end

  always_comb begin
    unique case (day_origin)
      ORIGIN_MJD: offset = MJD_OFFSET;
      ORIGIN_TJD: offset = TJD_OFFSET;
      default:    offset = 25'sd0;
    endcase
    value_next = jdn_gap ? 25'sd0 : (jdn - offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        sum_valid <= in_valid;
      end
      if (sum_ready) begin
        out_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      jdn     <= jdn_next;
      jdn_gap <= in_data.gap;
    end
    if (sum_ready && sum_valid) begin
      day_value <= value_next;
      gap_error <= jdn_gap;
    end
  end

endmodule
